[hdl/ivsp_pkg.sv]
`timescale 1ns / 1ps
// Package for the idle valve stepper positioner: field widths, register
// indexes, blend constants and the structs passed between modules. No dependencies.
package ivsp_pkg;

	// Field widths
	localparam int TEMP_W  = 19;
	localparam int RPM_W   = 14;
	localparam int TGT_W   = 12;
	localparam int STEP_W  = 10;
	localparam int PAT_W   = 16;
	localparam int COIL_W  = 4;
	localparam int NORM_W  = 8;
	localparam int PHASE_W = 12;
	localparam int ERRC_W  = 6;
	localparam int CLIP_W  = 17;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_STEPPER_ENABLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOME_STEPS       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS_OPEN_COLD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS_OPEN_HOT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_PATTERN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_PATTERN     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COIL_ENABLE_MASK = 3'd6;

	// Temperature blend: opening = ((SPAN - c) * COLD + c * HOT) / SPAN
	localparam int TEMP_SPAN  = 100000;
	localparam int NORM_COLD  = 255;
	localparam int NORM_HOT   = 50;
	localparam int BLEND_W    = 25;
	localparam logic [CLIP_W-1:0]  TEMP_SPAN_C = CLIP_W'(TEMP_SPAN);
	localparam logic [BLEND_W-1:0] BLEND_BASE  = BLEND_W'(TEMP_SPAN * NORM_COLD);
	localparam logic [7:0]         BLEND_SLOPE = 8'(NORM_COLD - NORM_HOT);

	// 100000 = 32 * 3125: drop five bits, then multiply by ceil(2^32 / 3125)
	localparam int DIV_PRESHIFT = 5;
	localparam int QUOT_IN_W    = BLEND_W - DIV_PRESHIFT;
	localparam int RECIP_W      = 21;
	localparam int RECIP_SHIFT  = 32;
	localparam logic [RECIP_W-1:0] RECIP_MUL = 21'd1374390;

	// Speed error bands
	localparam logic [RPM_W-1:0] ERR_BAND  = 14'd60;
	localparam logic [RPM_W-1:0] ERR_LARGE = 14'd250;

	typedef struct packed {
		logic                  stepper_enable;
		logic [STEP_W-1:0]     home_steps;
		logic [STEP_W-1:0]     steps_open_cold;
		logic [STEP_W-1:0]     steps_open_hot;
		logic [PAT_W-1:0]      close_pattern;
		logic [PAT_W-1:0]      open_pattern;
		logic [COIL_W-1:0]     coil_enable_mask;
	} ivsp_cfg_t;

	// Request fields as they reach the position update
	typedef struct packed {
		logic [RPM_W-1:0]  engine_rpm;
		logic [TGT_W-1:0]  idle_target_rpm;
		logic              closed_loop;
		logic [NORM_W-1:0] ol_norm;
	} ivsp_work_t;

	typedef struct packed {
		logic [COIL_W-1:0] coil_drive;
		logic              coils_active;
		logic [STEP_W-1:0] valve_position;
		logic [STEP_W-1:0] target_position;
		logic              homing;
	} ivsp_res_t;

	// Pipeline load strobes for the blend stages
	typedef struct packed {
		logic load_s2;
		logic load_s3;
	} ivsp_adv_t;

endpackage

[hdl/ivsp_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for tick requests and results.
// Depends on ivsp_pkg for field widths.
interface ivsp_tick_if;
	logic                                valid;
	logic                                ready;
	logic signed [ivsp_pkg::TEMP_W-1:0]  coolant_temp;
	logic        [ivsp_pkg::RPM_W-1:0]   engine_rpm;
	logic        [ivsp_pkg::TGT_W-1:0]   idle_target_rpm;
	logic                                closed_loop;

	modport source (output valid, coolant_temp, engine_rpm, idle_target_rpm, closed_loop,
		input ready);
	modport sink (input valid, coolant_temp, engine_rpm, idle_target_rpm, closed_loop,
		output ready);
endinterface

interface ivsp_result_if;
	logic                          valid;
	logic                          ready;
	logic [ivsp_pkg::COIL_W-1:0]   coil_drive;
	logic                          coils_active;
	logic [ivsp_pkg::STEP_W-1:0]   valve_position;
	logic [ivsp_pkg::STEP_W-1:0]   target_position;
	logic                          homing;

	modport source (output valid, coil_drive, coils_active, valve_position, target_position,
		homing, input ready);
	modport sink (input valid, coil_drive, coils_active, valve_position, target_position,
		homing, output ready);
endinterface

[hdl/ivsp_cfg.sv]
`timescale 1ns / 1ps
// Configuration register file: decodes the write port into the register set.
// Depends on ivsp_pkg.
module ivsp_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ivsp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ivsp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output ivsp_pkg::ivsp_cfg_t                cfg
);
	import ivsp_pkg::*;

	ivsp_cfg_t regs_q;

	// Register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEPPER_ENABLE:   regs_q.stepper_enable   <= cfg_wdata[0];
				REG_HOME_STEPS:       regs_q.home_steps       <= cfg_wdata[STEP_W-1:0];
				REG_STEPS_OPEN_COLD:  regs_q.steps_open_cold  <= cfg_wdata[STEP_W-1:0];
				REG_STEPS_OPEN_HOT:   regs_q.steps_open_hot   <= cfg_wdata[STEP_W-1:0];
				REG_CLOSE_PATTERN:    regs_q.close_pattern    <= cfg_wdata[PAT_W-1:0];
				REG_OPEN_PATTERN:     regs_q.open_pattern     <= cfg_wdata[PAT_W-1:0];
				REG_COIL_ENABLE_MASK: regs_q.coil_enable_mask <= cfg_wdata[COIL_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = regs_q;

endmodule

[hdl/ivsp_blend.sv]
`timescale 1ns / 1ps
// Two-stage temperature blend: clip and weight the coolant temperature, then
// divide by the span with a reciprocal multiply. Depends on ivsp_pkg.
module ivsp_blend (
	input  logic                              clk,
	input  ivsp_pkg::ivsp_adv_t               adv,
	input  logic signed [ivsp_pkg::TEMP_W-1:0] temp_s1,
	output logic [ivsp_pkg::NORM_W-1:0]       ol_norm_s3
);
	import ivsp_pkg::*;

	logic [CLIP_W-1:0]          clip_t;
	logic [BLEND_W-1:0]         numer;
	logic [QUOT_IN_W-1:0]       numer_s2;
	logic [QUOT_IN_W+RECIP_W-1:0] quot_prod;

	// Clip to 0..span; numerator = span*cold - (cold-hot)*c
	always_comb begin
		if (temp_s1[TEMP_W-1]) begin
			clip_t = '0;
		end else if (temp_s1[TEMP_W-2:0] > {1'b0, TEMP_SPAN_C}) begin
			clip_t = TEMP_SPAN_C;
		end else begin
			clip_t = temp_s1[CLIP_W-1:0];
		end
		numer = BLEND_BASE - BLEND_W'({8'd0, clip_t} * {17'd0, BLEND_SLOPE});
	end

	always_ff @(posedge clk) begin
		if (adv.load_s2) begin
			numer_s2 <= numer[BLEND_W-1:DIV_PRESHIFT];
		end
	end

	// Exact floor division by 3125 for a 20-bit dividend
	assign quot_prod = {{RECIP_W{1'b0}}, numer_s2} * {{QUOT_IN_W{1'b0}}, RECIP_MUL};

	always_ff @(posedge clk) begin
		if (adv.load_s3) begin
			ol_norm_s3 <= quot_prod[RECIP_SHIFT+NORM_W-1:RECIP_SHIFT];
		end
	end

endmodule

[hdl/ivsp_core.sv]
`timescale 1ns / 1ps
// Valve position state and per-tick update: homing, closed-loop nudging,
// learned minimum and coil phase sequencing. Depends on ivsp_pkg.
module ivsp_core #(
	parameter int LEARN_PERIOD = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  ivsp_pkg::ivsp_cfg_t  cfg,
	input  ivsp_pkg::ivsp_work_t work,
	output ivsp_pkg::ivsp_res_t  res
);
	import ivsp_pkg::*;

	localparam int SETTLE_W = $clog2(LEARN_PERIOD);
	localparam logic [SETTLE_W-1:0] SETTLE_LAST = SETTLE_W'(LEARN_PERIOD - 1);
	localparam logic [SETTLE_W:0]   SETTLE_WRAP = (SETTLE_W + 1)'(LEARN_PERIOD);

	typedef struct packed {
		logic                 homing_phase;
		logic [PHASE_W-1:0]   phase_counter;
		logic [PHASE_W-1:0]   phase_limit;
		logic [PAT_W-1:0]     active_pattern;
		logic [NORM_W-1:0]    norm_opening;
		logic [STEP_W-1:0]    goal_step;
		logic [STEP_W-1:0]    tracked_step;
		logic [STEP_W-1:0]    learned_min;
		logic                 learned_valid;
		logic [SETTLE_W-1:0]  settle_count;
		logic [ERRC_W-1:0]    error_count;
	} ivsp_state_t;

	// Everything clear except the homing flag
	localparam ivsp_state_t ST_RESET = '{homing_phase: 1'b1, default: '0};

	ivsp_state_t st_q, st_d;

	logic                 tgt_above;
	logic [RPM_W-1:0]     abs_err;
	logic                 err_big, err_large, under_min;
	logic [ERRC_W-1:0]    err_inc, err_mask;
	logic [SETTLE_W:0]    settle_inc;
	logic [SETTLE_W-1:0]  settle_nx;
	logic [STEP_W-1:0]    half_hot;

	logic [NORM_W-1:0]    cl_norm;
	logic [ERRC_W-1:0]    cl_err;
	logic [SETTLE_W-1:0]  cl_settle;
	logic [STEP_W-1:0]    cl_lmin;
	logic                 cl_lvalid;

	logic [NORM_W-1:0]    goal_norm;
	logic [NORM_W+STEP_W-1:0] goal_prod;
	logic [STEP_W-1:0]    goal_new;

	logic [PHASE_W-1:0]   cnt_inc;
	logic [COIL_W-1:0]    drive;
	logic                 active;

	// Speed error and cadence terms
	assign tgt_above  = {2'b00, work.idle_target_rpm} > work.engine_rpm;
	assign abs_err    = tgt_above ? ({2'b00, work.idle_target_rpm} - work.engine_rpm)
		: (work.engine_rpm - {2'b00, work.idle_target_rpm});
	assign err_big    = abs_err > ERR_BAND;
	assign err_large  = abs_err > ERR_LARGE;
	assign err_inc    = st_q.error_count + ERRC_W'(1);
	assign under_min  = !st_q.learned_valid || (st_q.learned_min >= st_q.goal_step);
	assign err_mask   = err_large ? (under_min ? 6'd15 : 6'd7) : (under_min ? 6'd63 : 6'd15);
	assign settle_inc = {1'b0, st_q.settle_count} + (SETTLE_W + 1)'(1);
	assign settle_nx  = (settle_inc >= SETTLE_WRAP) ? '0 : settle_inc[SETTLE_W-1:0];
	assign half_hot   = cfg.steps_open_hot >> 1;

	// Opening update for a settled tick outside homing
	always_comb begin
		cl_norm   = st_q.norm_opening;
		cl_err    = st_q.error_count;
		cl_settle = st_q.settle_count;
		cl_lmin   = st_q.learned_min;
		cl_lvalid = st_q.learned_valid;
		if (!work.closed_loop) begin
			cl_norm   = work.ol_norm;
			cl_settle = '0;
		end else if (err_big) begin
			cl_err    = err_inc;
			cl_settle = '0;
			if (tgt_above) begin
				if (err_inc[1:0] == 2'b00 && work.ol_norm > st_q.norm_opening) begin
					cl_norm = st_q.norm_opening + NORM_W'(1);
				end
			end else if (cfg.steps_open_hot != '0) begin
				if ((err_inc & err_mask) == '0 && st_q.norm_opening != '0) begin
					cl_norm = st_q.norm_opening - NORM_W'(1);
				end
			end
		end else begin
			cl_err    = '0;
			cl_settle = settle_nx;
			// learn the minimum once per settle period
			if (settle_nx == SETTLE_LAST) begin
				if (!st_q.learned_valid) begin
					cl_lmin   = st_q.tracked_step;
					cl_lvalid = 1'b1;
				end else if (st_q.tracked_step < st_q.learned_min) begin
					if (st_q.learned_min - st_q.tracked_step > half_hot) begin
						cl_lmin = st_q.learned_min - half_hot;
					end else begin
						cl_lmin = st_q.learned_min - STEP_W'(1);
					end
				end else if (st_q.tracked_step > st_q.learned_min) begin
					cl_lmin = st_q.tracked_step;
				end
			end
		end
	end

	// Goal step from the opening in force after this tick
	assign goal_norm = st_q.homing_phase ? work.ol_norm : cl_norm;
	assign goal_prod = {{STEP_W{1'b0}}, goal_norm} * {{NORM_W{1'b0}}, cfg.steps_open_cold};
	assign goal_new  = goal_prod[NORM_W+STEP_W-1:NORM_W];

	// Next state and coil phase
	always_comb begin
		st_d   = st_q;
		drive  = '0;
		active = 1'b0;
		cnt_inc = '0;
		if (cfg.stepper_enable) begin
			if (st_q.homing_phase) begin
				if (st_q.phase_limit == '0) begin
					st_d.phase_counter  = '0;
					st_d.norm_opening   = '0;
					st_d.goal_step      = '0;
					st_d.phase_limit    = {cfg.home_steps, 2'b00};
					st_d.learned_valid  = 1'b0;
					st_d.learned_min    = '0;
					st_d.settle_count   = '0;
					st_d.active_pattern = cfg.close_pattern;
				end else if (st_q.phase_limit == st_q.phase_counter) begin
					st_d.phase_counter  = '0;
					st_d.norm_opening   = work.ol_norm;
					st_d.goal_step      = goal_new;
					st_d.tracked_step   = '0;
					st_d.phase_limit    = {goal_new, 2'b00};
					st_d.active_pattern = cfg.open_pattern;
					st_d.homing_phase   = 1'b0;
				end
			end else if (st_q.phase_limit == st_q.phase_counter) begin
				st_d.norm_opening  = cl_norm;
				st_d.error_count   = cl_err;
				st_d.settle_count  = cl_settle;
				st_d.learned_min   = cl_lmin;
				st_d.learned_valid = cl_lvalid;
				st_d.goal_step     = goal_new;
				// start a full step when more than one step away
				if ({1'b0, goal_new} > {1'b0, st_q.tracked_step} + 11'd1 ||
					{1'b0, st_q.tracked_step} > {1'b0, goal_new} + 11'd1) begin
					st_d.active_pattern = (goal_new < st_q.tracked_step) ? cfg.close_pattern
						: cfg.open_pattern;
					st_d.phase_limit   = PHASE_W'(4);
					st_d.phase_counter = '0;
				end
			end

			if (st_d.phase_limit > st_d.phase_counter) begin
				drive  = COIL_W'(st_d.active_pattern >> {st_d.phase_counter[1:0], 2'b00})
					& cfg.coil_enable_mask;
				active = 1'b1;
				cnt_inc = st_d.phase_counter + PHASE_W'(1);
				st_d.phase_counter = cnt_inc;
				// a full step ends every fourth phase
				if (cnt_inc[1:0] == 2'b00) begin
					if (st_d.tracked_step > st_d.goal_step) begin
						st_d.tracked_step = st_d.tracked_step - STEP_W'(1);
					end else if (st_d.tracked_step < st_d.goal_step) begin
						st_d.tracked_step = st_d.tracked_step + STEP_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (fire) begin
			st_q <= st_d;
		end
	end

	assign res.coil_drive      = drive;
	assign res.coils_active    = active;
	assign res.valve_position  = st_d.tracked_step;
	assign res.target_position = st_d.goal_step;
	assign res.homing          = st_d.homing_phase;

endmodule

[hdl/idle_valve_stepper_positioner.sv]
`timescale 1ns / 1ps
// Top level of the idle valve stepper positioner: request pipeline, flow
// control and result register. Depends on ivsp_pkg, ivsp_if, ivsp_cfg, ivsp_blend, ivsp_core.
//
//  Channel  Direction  Handshake      Carries
//  tick     sink       valid / ready  coolant_temp, engine_rpm, idle_target_rpm, closed_loop
//  result   source     valid / ready  coil_drive, coils_active, valve_position,
//                                     target_position, homing
//  cfg      sink       cfg_we         cfg_index, cfg_wdata
//
// One request per cycle sustained while the result channel is not stalled; each request's
// result passes the input register, two blend stages and the result register.
// The valve state updates as a request leaves the third stage into the result register.
// Reset clears the pipeline and the registers and enters homing.
// A stalled result holds in its register; requests keep entering until all stages fill.
module idle_valve_stepper_positioner #(
	parameter int LEARN_PERIOD = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	ivsp_tick_if.sink                        tick,
	ivsp_result_if.source                    result,
	input  logic                             cfg_we,
	input  logic [ivsp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ivsp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import ivsp_pkg::*;

	typedef struct packed {
		logic [RPM_W-1:0] engine_rpm;
		logic [TGT_W-1:0] idle_target_rpm;
		logic             closed_loop;
	} ivsp_speed_t;

	ivsp_cfg_t            cfg;
	ivsp_adv_t            adv;
	ivsp_work_t           work;
	ivsp_res_t            res_d, res_q;

	logic                 v_s1, v_s2, v_s3, res_valid_q;
	logic                 out_free, s3_free, s2_free, s1_free, fire;
	logic signed [TEMP_W-1:0] temp_s1;
	ivsp_speed_t          spd_s1, spd_s2, spd_s3;
	logic [NORM_W-1:0]    ol_norm_s3;

	// Stage movement, back to front
	assign out_free    = !res_valid_q || result.ready;
	assign fire        = v_s3 && out_free;
	assign s3_free     = !v_s3 || out_free;
	assign s2_free     = !v_s2 || s3_free;
	assign s1_free     = !v_s1 || s2_free;
	assign adv.load_s3 = v_s2 && s3_free;
	assign adv.load_s2 = v_s1 && s2_free;
	assign tick.ready  = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1 <= tick.valid;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
			if (s3_free) begin
				v_s3 <= v_s2;
			end
			if (out_free) begin
				res_valid_q <= v_s3;
			end
		end
	end

	// Request payload along the pipeline
	always_ff @(posedge clk) begin
		if (tick.valid && s1_free) begin
			temp_s1                <= tick.coolant_temp;
			spd_s1.engine_rpm      <= tick.engine_rpm;
			spd_s1.idle_target_rpm <= tick.idle_target_rpm;
			spd_s1.closed_loop     <= tick.closed_loop;
		end
		if (adv.load_s2) begin
			spd_s2 <= spd_s1;
		end
		if (adv.load_s3) begin
			spd_s3 <= spd_s2;
		end
		if (fire) begin
			res_q <= res_d;
		end
	end

	ivsp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ivsp_blend u_blend (
		.clk        (clk),
		.adv        (adv),
		.temp_s1    (temp_s1),
		.ol_norm_s3 (ol_norm_s3)
	);

	assign work.engine_rpm      = spd_s3.engine_rpm;
	assign work.idle_target_rpm = spd_s3.idle_target_rpm;
	assign work.closed_loop     = spd_s3.closed_loop;
	assign work.ol_norm         = ol_norm_s3;

	ivsp_core #(
		.LEARN_PERIOD (LEARN_PERIOD)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cfg    (cfg),
		.work   (work),
		.res    (res_d)
	);

	// Result channel
	assign result.valid           = res_valid_q;
	assign result.coil_drive      = res_q.coil_drive;
	assign result.coils_active    = res_q.coils_active;
	assign result.valve_position  = res_q.valve_position;
	assign result.target_position = res_q.target_position;
	assign result.homing          = res_q.homing;

endmodule
